// ===== rtl/ptn_pkg.sv =====
// Package for the pitch-to-note converter: scale constants, sequencer state
// types and the result struct passed from the slot scanner to the top level.
// No dependencies.
`default_nettype none

package ptn_pkg;

  localparam int unsigned PITCH_W   = 16;
  localparam int unsigned OCT_W     = 4;
  localparam int unsigned SCALE_W   = 14;
  localparam int unsigned RATIO_W   = 13;
  localparam int unsigned PROD_W    = SCALE_W + RATIO_W;
  localparam int unsigned ACC_W     = 30;
  localparam int unsigned CMP_W     = ACC_W - 12;
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned SUB_W     = 5;
  localparam int unsigned INDEX_W   = STEP_W + SUB_W;

  localparam logic [SCALE_W-1:0] SCALE_ONE   = 14'h1000;
  localparam logic [RATIO_W-1:0] SCALE_RATIO = 13'h103B;
  localparam logic [STEP_W-1:0]  LAST_STEP   = 6'd47;
  localparam logic [SUB_W-1:0]   LAST_SUB    = 5'd31;
  localparam logic [INDEX_W-1:0] NO_MATCH    = 11'd1536;
  localparam logic [9:0]         NOTE_BIAS   = 10'd144;
  localparam logic [9:0]         SEMIS_PER_OCT = 10'd12;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MUL,
    SC_SETUP,
    SC_SUB,
    SC_DONE
  } scan_state_t;

  typedef enum logic [1:0] {
    TP_IDLE,
    TP_RUN,
    TP_HOLD
  } top_state_t;

  typedef struct packed {
    logic               done;
    logic [INDEX_W-1:0] index;
    logic [OCT_W-1:0]   octave;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/ptn_if.sv =====
// Valid/ready channel interfaces for the pitch-to-note converter.
// Depends on nothing; used by the top level and its environment.
`default_nettype none

interface ptn_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] pitch;
  logic [7:0]  center_note;
  logic [7:0]  center_fine;

  modport source (output valid, pitch, center_note, center_fine, input ready);
  modport sink   (input valid, pitch, center_note, center_fine, output ready);
endinterface

interface ptn_rsp_if;
  logic              valid;
  logic              ready;
  logic [31:0]       packed_result;
  logic signed [9:0] note_value;
  logic [8:0]        fine_value;

  modport source (output valid, packed_result, note_value, fine_value, input ready);
  modport sink   (input valid, packed_result, note_value, fine_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/ptn_scan.sv =====
// Slot scanner: finds the octave of the pitch, then walks 48 scale steps of
// 32 sub-slots each with one multiplier and one adder/comparator.
// Depends on ptn_pkg.
`default_nettype none

module ptn_scan import ptn_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [PITCH_W-1:0] pitch,
  output scan_res_t               res
);

  scan_state_t         state, state_next;
  logic [PITCH_W-1:0]  p;
  logic [OCT_W-1:0]    octave;
  logic [SCALE_W-1:0]  scale;
  logic [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]    inc;
  logic [ACC_W-1:0]    acc;
  logic [STEP_W-1:0]   step;
  logic [SUB_W-1:0]    sub;
  logic [INDEX_W-1:0]  index;

  logic [OCT_W-1:0]    top_bit;
  logic [SCALE_W-1:0]  scale_new;
  logic [SCALE_W-1:0]  scale_diff;
  logic [ACC_W-1:0]    sum;
  logic [CMP_W-1:0]    lo;
  logic [CMP_W-1:0]    hi;
  logic [CMP_W-1:0]    p_ext;
  logic                match;

  // highest set bit; zero pitch gives bit 0
  always_comb begin
    top_bit = '0;
    for (int b = 0; b < PITCH_W; b++) begin
      if (pitch[b]) top_bit = OCT_W'(b);
    end
  end

  assign scale_new  = prod[PROD_W-2 -: SCALE_W];
  assign scale_diff = scale_new - scale;
  assign sum        = acc + inc;
  assign lo         = acc[ACC_W-1 -: CMP_W];
  assign hi         = sum[ACC_W-1 -: CMP_W];
  assign p_ext      = CMP_W'(p);
  assign match      = (p_ext >= lo) && (p_ext < hi);

  always_comb begin
    state_next = state;
    unique case (state)
      SC_IDLE:  if (start) state_next = SC_MUL;
      SC_MUL:   state_next = SC_SETUP;
      SC_SETUP: state_next = SC_SUB;
      SC_SUB: begin
        if (match) state_next = SC_DONE;
        else if (sub == LAST_SUB) begin
          state_next = (step == LAST_STEP) ? SC_DONE : SC_MUL;
        end
      end
      SC_DONE:  state_next = SC_IDLE;
      default:  state_next = SC_IDLE;
    endcase
  end

  always_comb begin
    res.done   = (state == SC_DONE);
    res.index  = index;
    res.octave = octave;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SC_IDLE: begin
        if (start) begin
          p      <= pitch;
          octave <= top_bit;
          scale  <= SCALE_ONE;
          step   <= '0;
          index  <= NO_MATCH;
        end
      end
      SC_MUL: begin
        prod <= PROD_W'(scale) * PROD_W'(SCALE_RATIO);
      end
      SC_SETUP: begin
        // bounds of one step are scale << octave; slot width is the gap / 32
        acc   <= ACC_W'(scale) << octave;
        inc   <= (ACC_W'(scale_diff) << octave) >> SUB_W;
        scale <= scale_new;
        sub   <= '0;
      end
      SC_SUB: begin
        if (match) begin
          index <= {step, sub};
        end else begin
          acc <= sum;
          sub <= sub + 1'b1;
          if (sub == LAST_SUB) step <= step + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/pitch_to_note_fine.sv =====
// Pitch-to-note converter, top level: input capture, scanner control,
// note/fine arithmetic and output register.
// Depends on ptn_pkg, ptn_req_if, ptn_rsp_if and ptn_scan.
//
// Usage:
//   req carries pitch, center_note and center_fine; an item is taken when
//   req.valid and req.ready are both high. rsp carries packed_result,
//   note_value and fine_value under the same valid/ready rule.
//   One item is converted at a time. req.ready is high only while no
//   conversion runs. From accept to rsp.valid a conversion passes a scale
//   multiply and a slot setup for each scale step entered, one compare per
//   slot until a slot matches or all slots are walked, then the done flag.
//   The next item can be taken in the same cycle in which rsp.valid rises;
//   the slot walk on the single adder/comparator sets the spacing of items.
//   The result sits in an output register, so a new item can be accepted
//   while an earlier result still waits for rsp.ready. If the receiver
//   stalls and the register is still full when the next conversion ends,
//   that conversion waits and req.ready stays low until it is moved out.
//   Synchronous reset (rst) empties the output register and returns both
//   sequencers to idle; no clearing pass is needed.
`default_nettype none

module pitch_to_note_fine import ptn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  ptn_req_if.sink   req,
  ptn_rsp_if.source rsp
);

  top_state_t        state, state_next;
  logic [7:0]        cn;
  logic [7:0]        cf;
  logic              out_valid;
  logic [31:0]       out_packed;
  logic signed [9:0] out_note;
  logic [8:0]        out_fine;

  logic              accept;
  logic              load;
  logic              out_free;
  scan_res_t         scan_res;
  logic [9:0]        note_calc;
  logic [8:0]        fine_calc;
  logic [31:0]       packed_calc;

  ptn_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .pitch (req.pitch),
    .res   (scan_res)
  );

  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      TP_IDLE: if (accept) state_next = TP_RUN;
      TP_RUN: begin
        if (scan_res.done) state_next = out_free ? TP_IDLE : TP_HOLD;
      end
      TP_HOLD: if (out_free) state_next = TP_IDLE;
      default: state_next = TP_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == TP_IDLE);
    accept    = req.valid && (state == TP_IDLE);
    unique case (state)
      TP_RUN:  load = scan_res.done && out_free;
      TP_HOLD: load = out_free;
      default: load = 1'b0;
    endcase
  end

  // scanner holds index and octave until its next start
  assign note_calc = 10'(cn) + 10'(scan_res.index[INDEX_W-1:7])
                   + 10'(scan_res.octave) * SEMIS_PER_OCT - NOTE_BIAS;
  assign fine_calc = 9'(cf) + 9'(scan_res.index[6:0]);
  assign packed_calc = ({{22{note_calc[9]}}, note_calc} << 8) | 32'(fine_calc);

  assign rsp.valid         = out_valid;
  assign rsp.packed_result = out_packed;
  assign rsp.note_value    = out_note;
  assign rsp.fine_value    = out_fine;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= TP_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cn <= req.center_note;
      cf <= req.center_fine;
    end
    if (load) begin
      out_packed <= packed_calc;
      out_note   <= note_calc;
      out_fine   <= fine_calc;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ptn_checker.sv =====
// Port-level checks for the pitch-to-note converter, bound to the top level.
// Depends on pitch_to_note_fine's clock, reset and channel ports only.
`default_nettype none

module ptn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [31:0] packed_result,
  input wire logic [9:0]  note_value,
  input wire logic [8:0]  fine_value
);

  // waiting result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("rsp.valid dropped while stalled");

  // a stalled result keeps its value
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(packed_result))
    else $error("packed_result changed while stalled");

  // one conversion at a time: busy right after an accepted item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req.ready high right after an accepted item");

  // packed word agrees with the separate note and fine fields
  a_packed: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (packed_result[7:0] == fine_value[7:0])
               && (packed_result[8] == (note_value[0] | fine_value[8]))
               && (packed_result[17:9] == note_value[9:1]))
    else $error("packed_result does not match note/fine fields");

  // note stays inside its reachable range
  a_note_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ($signed(note_value) >= -10'sd144)
               && ($signed(note_value) <= 10'sd303) && (fine_value <= 9'd382))
    else $error("note or fine value out of range");

endmodule

bind pitch_to_note_fine ptn_checker u_ptn_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .packed_result (rsp.packed_result),
  .note_value    (rsp.note_value),
  .fine_value    (rsp.fine_value)
);

`default_nettype wire
